### rtl/spq_pkg.sv
// Shared constants, codes and types for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

    // Payload widths fixed by the item format
    localparam int DATA_W      = 32;
    localparam int CFG_W       = 7;
    localparam int STATUS_W    = 2;
    localparam int CAP_DEFAULT = 64;

    localparam logic [CFG_W-1:0] CAP_RESET = 7'd64;

    // Request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic                     cmp;        // latch compare flags
        logic                     ins_commit; // apply insert shift
        logic                     del_commit; // apply delete shift
        logic signed [DATA_W-1:0] value;      // request value
    } t_cell_ctl;

endpackage

### rtl/spq_if.sv
// Handshake interfaces for the request, result and configuration channels.
`timescale 1ns / 1ps

interface spq_req_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic signed [spq_pkg::DATA_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface spq_res_if #(
    parameter int CNT_W = 7
);
    logic                                valid;
    logic                                ready;
    logic [spq_pkg::STATUS_W-1:0]        status;
    logic [CNT_W-1:0]                    count;
    logic signed [spq_pkg::DATA_W-1:0]   head_value;

    modport source (output valid, output status, output count, output head_value,
                    input ready);
    modport sink   (input valid, input status, input count, input head_value,
                    output ready);
endinterface

interface spq_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [spq_pkg::CFG_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/spq_cell.sv
// One compare-and-shift cell of the sorted entry chain.
`timescale 1ns / 1ps

module spq_cell (
    input  logic                              i_clk,
    input  spq_pkg::t_cell_ctl                i_ctl,
    input  logic                              i_occ,
    input  logic signed [spq_pkg::DATA_W-1:0] i_left_entry,
    input  logic                              i_left_flag,
    input  logic signed [spq_pkg::DATA_W-1:0] i_right_entry,
    output logic signed [spq_pkg::DATA_W-1:0] o_entry,
    output logic signed [spq_pkg::DATA_W-1:0] o_next,
    output logic                              o_flag,
    output logic                              o_eq
);

    logic signed [spq_pkg::DATA_W-1:0] r_entry;
    logic signed [spq_pkg::DATA_W-1:0] n_entry;
    logic                              r_flag;
    logic                              r_eq;

    // Flag: request value sits at or ahead of this slot (empty slots always do)
    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_flag <= !i_occ || (i_ctl.value >= r_entry);
            r_eq   <= i_occ && (i_ctl.value == r_entry);
        end
    end

    // Insert: shift back from the left neighbour, or take the new value at the
    // boundary. Delete: pull forward from the right neighbour past the boundary.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins_commit && r_flag) begin
            n_entry = i_left_flag ? i_left_entry : i_ctl.value;
        end else if (i_ctl.del_commit && r_flag) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ins_commit || i_ctl.del_commit) begin
            r_entry <= n_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_next  = n_entry;
    assign o_flag  = r_flag;
    assign o_eq    = r_eq;

endmodule

### rtl/sorted_priority_queue_core.sv
// Top level: sorted priority queue built from a chain of compare-and-shift cells.
//
//   channel   dir   handshake          payload
//   i_req     in    valid / ready      req_type, value
//   o_res     out   valid / ready      status, count, head_value
//   i_cfg     in    valid / ready      data (capacity)
//
// Each item passes a compare state, which latches compare flags in every
// cell, then an update state, which shifts the chain and loads the result
// register; a new item can be taken while the last is in its update state.
// A result waiting in the output register does not block the next item's
// compare cycle; the update cycle holds until the register is free.
// Synchronous active-low reset clears count, state, result valid; capacity = 64.
`timescale 1ns / 1ps

module sorted_priority_queue_core #(
    parameter int CAPACITY = spq_pkg::CAP_DEFAULT,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    spq_req_if.sink        i_req,
    spq_res_if.source      o_res,
    spq_cfg_if.sink        i_cfg
);

    localparam int CMP_W = (CNT_W > spq_pkg::CFG_W) ? CNT_W : spq_pkg::CFG_W;

    spq_pkg::t_state                   r_state;
    spq_pkg::t_state                   n_state;
    logic [CNT_W-1:0]                  r_count;
    logic [spq_pkg::CFG_W-1:0]         r_capacity;
    logic                              r_req_type;
    logic signed [spq_pkg::DATA_W-1:0] r_value;
    logic                              r_out_valid;
    logic [spq_pkg::STATUS_W-1:0]      r_out_status;
    logic [CNT_W-1:0]                  r_out_count;
    logic signed [spq_pkg::DATA_W-1:0] r_out_head;

    spq_pkg::t_cell_ctl                cell_ctl;
    logic signed [spq_pkg::DATA_W-1:0] cell_entry [CAPACITY];
    logic signed [spq_pkg::DATA_W-1:0] cell_next  [CAPACITY];
    logic [CAPACITY-1:0]               cell_flag;
    logic [CAPACITY-1:0]               cell_eq;
    logic [CAPACITY-1:0]               cell_occ;

    logic                              accept;
    logic                              upd_go;
    logic                              full;
    logic                              found;
    logic [spq_pkg::STATUS_W-1:0]      status;
    logic [CNT_W-1:0]                  n_count;

    // Configuration: always ready; to be written only while idle (the block does not enforce this)
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= spq_pkg::CAP_RESET;
        end else if (i_cfg.valid) begin
            r_capacity <= i_cfg.data;
        end
    end

    // Handshake and sequencing
    assign upd_go      = (r_state == spq_pkg::S_UPD) && (!r_out_valid || o_res.ready);
    assign i_req.ready = (r_state == spq_pkg::S_IDLE) || upd_go;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spq_pkg::S_IDLE: if (accept) n_state = spq_pkg::S_CMP;
            spq_pkg::S_CMP:  n_state = spq_pkg::S_UPD;
            spq_pkg::S_UPD: begin
                if (upd_go) begin
                    n_state = accept ? spq_pkg::S_CMP : spq_pkg::S_IDLE;
                end
            end
            default:         n_state = spq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req.req_type;
            r_value    <= i_req.value;
        end
    end

    // Status decision in the update cycle
    assign full  = (CMP_W'(r_count) >= CMP_W'(r_capacity))
                   || (r_count == CNT_W'(CAPACITY));
    assign found = |cell_eq;

    always_comb begin
        status  = spq_pkg::ST_OK;
        n_count = r_count;
        if (r_req_type == spq_pkg::REQ_INSERT) begin
            if (full) begin
                status = spq_pkg::ST_OVERFLOW;
            end else begin
                n_count = r_count + 1'b1;
            end
        end else begin
            if (r_count == '0) begin
                status = spq_pkg::ST_UNDERFLOW;
            end else if (!found) begin
                status = spq_pkg::ST_NOTFOUND;
            end else begin
                n_count = r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (upd_go) begin
            r_count <= n_count;
        end
    end

    // Broadcast to the chain
    always_comb begin
        cell_ctl.cmp        = (r_state == spq_pkg::S_CMP);
        cell_ctl.ins_commit = upd_go && (r_req_type == spq_pkg::REQ_INSERT)
                              && (status == spq_pkg::ST_OK);
        cell_ctl.del_commit = upd_go && (r_req_type == spq_pkg::REQ_DELETE)
                              && (status == spq_pkg::ST_OK);
        cell_ctl.value      = r_value;
    end

    // Cell chain
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic signed [spq_pkg::DATA_W-1:0] left_entry;
        logic signed [spq_pkg::DATA_W-1:0] right_entry;
        logic                              left_flag;

        assign cell_occ[k] = (CMP_W'(r_count) > CMP_W'(k));

        if (k == 0) begin : g_head
            assign left_entry = r_value;
            assign left_flag  = 1'b0;
        end else begin : g_mid
            assign left_entry = cell_entry[k-1];
            assign left_flag  = cell_flag[k-1];
        end

        if (k == CAPACITY - 1) begin : g_tail
            assign right_entry = cell_entry[k];
        end else begin : g_body
            assign right_entry = cell_entry[k+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_occ         (cell_occ[k]),
            .i_left_entry  (left_entry),
            .i_left_flag   (left_flag),
            .i_right_entry (right_entry),
            .o_entry       (cell_entry[k]),
            .o_next        (cell_next[k]),
            .o_flag        (cell_flag[k]),
            .o_eq          (cell_eq[k])
        );
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (upd_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_go) begin
            r_out_status <= status;
            r_out_count  <= n_count;
            r_out_head   <= (n_count == '0) ? '0 : cell_next[0];
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.status     = r_out_status;
    assign o_res.count      = r_out_count;
    assign o_res.head_value = r_out_head;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(CAPACITY))
        else $error("stored count beyond chain length");

    a_upd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spq_pkg::S_UPD && r_out_valid && !o_res.ready)
        |=> (r_state == spq_pkg::S_UPD))
        else $error("update left while result register busy");

    a_no_take_in_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spq_pkg::S_CMP) |-> !i_req.ready)
        else $error("item taken during compare cycle");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_ctl.ins_commit) |=> (r_count == CNT_W'($past(r_count) + 1'b1)))
        else $error("insert did not grow the count by one");

endmodule
